/* rtl/core/hsv2rgb_pkg.sv */
// Package for the HSV to RGB converter: fixed-point widths, sector codes,
// stage payload structs and the fraction helpers. No dependencies.
`default_nettype none

package hsv2rgb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int FIELD_W   = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * FIELD_W;
    localparam int SCALED_W  = FIELD_W + 3;

    localparam logic [FIELD_W-1:0]  ONE_FX    = FIELD_W'(1) << FRAC_BITS;
    localparam logic [SCALED_W-1:0] HUE_SCALE = SCALED_W'(6);

    // Hue sectors after hue*6; sector six wraps to sector zero
    localparam logic [2:0] SECT_0    = 3'd0;
    localparam logic [2:0] SECT_1    = 3'd1;
    localparam logic [2:0] SECT_2    = 3'd2;
    localparam logic [2:0] SECT_3    = 3'd3;
    localparam logic [2:0] SECT_4    = 3'd4;
    localparam logic [2:0] SECT_5    = 3'd5;
    localparam logic [2:0] SECT_WRAP = 3'd6;

    typedef struct packed {
        logic [2:0]           sector;
        logic [FRAC_BITS-1:0] frac;
        logic [FIELD_W-1:0]   sat;
        logic [FIELD_W-1:0]   val;
    } sect_t;

    typedef struct packed {
        logic [2:0]         sector;
        logic [FIELD_W-1:0] val;
        logic [FIELD_W-1:0] tb;
        logic [FIELD_W-1:0] sf;
        logic [FIELD_W-1:0] s1f;
    } prod_t;

    typedef struct packed {
        logic [2:0]         sector;
        logic [FIELD_W-1:0] ta;
        logic [FIELD_W-1:0] tb;
        logic [FIELD_W-1:0] tc;
        logic [FIELD_W-1:0] td;
    } term_t;

    // Saturate a field to 1.0
    function automatic logic [FIELD_W-1:0] clamp_frac(input logic [FIELD_W-1:0] x);
        return (x > ONE_FX) ? ONE_FX : x;
    endfunction

    // Fraction product, truncated; operands at most 1.0 keep the result in range
    function automatic logic [FIELD_W-1:0] mul_frac(input logic [FIELD_W-1:0] a,
                                                    input logic [FIELD_W-1:0] b);
        logic [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        return p[FRAC_BITS+FIELD_W-1:FRAC_BITS];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hsv2rgb_sector.sv */
// First stage of the HSV to RGB pipeline: clamp inputs, scale hue by six,
// split sector and fraction. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_sector (
    input  wire logic                            clk,
    input  wire logic                            advance,
    input  wire logic [hsv2rgb_pkg::FIELD_W-1:0] hue,
    input  wire logic [hsv2rgb_pkg::FIELD_W-1:0] saturation,
    input  wire logic [hsv2rgb_pkg::FIELD_W-1:0] brightness,
    output hsv2rgb_pkg::sect_t                   sect
);

    hsv2rgb_pkg::sect_t                   sect_reg;
    hsv2rgb_pkg::sect_t                   sect_next;
    logic [hsv2rgb_pkg::FIELD_W-1:0]      hue_c;
    logic [hsv2rgb_pkg::SCALED_W-1:0]     scaled;
    logic [2:0]                           sector;

    always_comb
    begin
        hue_c  = hsv2rgb_pkg::clamp_frac(hue);
        scaled = hsv2rgb_pkg::SCALED_W'(hue_c) * hsv2rgb_pkg::HUE_SCALE;
        sector = scaled[hsv2rgb_pkg::FRAC_BITS+2:hsv2rgb_pkg::FRAC_BITS];

        sect_next.sat = hsv2rgb_pkg::clamp_frac(saturation);
        sect_next.val = hsv2rgb_pkg::clamp_frac(brightness);
        // Wrap hue of exactly 1.0 back to sector zero
        if (sector == hsv2rgb_pkg::SECT_WRAP)
        begin
            sect_next.sector = hsv2rgb_pkg::SECT_0;
            sect_next.frac   = '0;
        end
        else
        begin
            sect_next.sector = sector;
            sect_next.frac   = scaled[hsv2rgb_pkg::FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sect_reg <= sect_next;
        end
    end

    assign sect = sect_reg;

endmodule

`default_nettype wire

/* rtl/core/hsv2rgb_terms.sv */
// Second and third pipeline stages: form the products s*f, s*(1-f),
// v*(1-s), then v*(1-s*f) and v*(1-s*(1-f)). Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_terms (
    input  wire logic              clk,
    input  wire logic              advance,
    input  wire hsv2rgb_pkg::sect_t sect,
    output hsv2rgb_pkg::term_t     term
);

    hsv2rgb_pkg::prod_t prod_reg;
    hsv2rgb_pkg::prod_t prod_next;
    hsv2rgb_pkg::term_t term_reg;
    hsv2rgb_pkg::term_t term_next;
    logic [hsv2rgb_pkg::FIELD_W-1:0] frac_w;

    always_comb
    begin
        frac_w           = hsv2rgb_pkg::FIELD_W'(sect.frac);
        prod_next.sector = sect.sector;
        prod_next.val    = sect.val;
        prod_next.tb     = hsv2rgb_pkg::mul_frac(sect.val, hsv2rgb_pkg::ONE_FX - sect.sat);
        prod_next.sf     = hsv2rgb_pkg::mul_frac(sect.sat, frac_w);
        prod_next.s1f    = hsv2rgb_pkg::mul_frac(sect.sat, hsv2rgb_pkg::ONE_FX - frac_w);
    end

    always_comb
    begin
        term_next.sector = prod_reg.sector;
        term_next.ta     = prod_reg.val;
        term_next.tb     = prod_reg.tb;
        term_next.tc     = hsv2rgb_pkg::mul_frac(prod_reg.val,
                                                 hsv2rgb_pkg::ONE_FX - prod_reg.sf);
        term_next.td     = hsv2rgb_pkg::mul_frac(prod_reg.val,
                                                 hsv2rgb_pkg::ONE_FX - prod_reg.s1f);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

`default_nettype wire

/* rtl/core/hsv2rgb_route.sv */
// Last pipeline stage: route the four terms to red, green and blue by
// sector into the output register. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_route (
    input  wire logic                             clk,
    input  wire logic                             advance,
    input  wire hsv2rgb_pkg::term_t               term,
    output logic [hsv2rgb_pkg::FIELD_W-1:0]       red,
    output logic [hsv2rgb_pkg::FIELD_W-1:0]       green,
    output logic [hsv2rgb_pkg::FIELD_W-1:0]       blue
);

    logic [hsv2rgb_pkg::FIELD_W-1:0] red_reg,  red_next;
    logic [hsv2rgb_pkg::FIELD_W-1:0] green_reg, green_next;
    logic [hsv2rgb_pkg::FIELD_W-1:0] blue_reg, blue_next;

    always_comb
    begin
        case (term.sector)
            hsv2rgb_pkg::SECT_0:
            begin
                red_next = term.ta; green_next = term.td; blue_next = term.tb;
            end
            hsv2rgb_pkg::SECT_1:
            begin
                red_next = term.tc; green_next = term.ta; blue_next = term.tb;
            end
            hsv2rgb_pkg::SECT_2:
            begin
                red_next = term.tb; green_next = term.ta; blue_next = term.td;
            end
            hsv2rgb_pkg::SECT_3:
            begin
                red_next = term.tb; green_next = term.tc; blue_next = term.ta;
            end
            hsv2rgb_pkg::SECT_4:
            begin
                red_next = term.td; green_next = term.tb; blue_next = term.ta;
            end
            default:
            begin
                red_next = term.ta; green_next = term.tb; blue_next = term.tc;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

/* rtl/core/hsv_to_rgb_converter_unit.sv */
// Top level of the HSV to RGB converter: valid/stall control and the four
// pipeline stages. Depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_terms, hsv2rgb_route.
`default_nettype none

// Converts one HSV colour per transfer into one RGB triple. All fields are
// unsigned fractions with 12 fraction bits, 4096 meaning 1.0; inputs above
// 1.0 are saturated to 1.0. A new colour is taken every clock cycle unless
// hsv_stall is high, and its result passes through clamp and hue*6 split,
// the first fraction products, the value products, then sector routing into
// the output register. All four stages move together on one advance signal,
// so hsv_stall is high only while a result sits in the output register and
// rgb_stall holds it. Zero saturation gives grey without a separate path,
// since every term then equals the brightness. Products truncate.
module hsv_to_rgb_converter_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            hsv_valid,
    output logic                                 hsv_stall,
    input  wire logic [hsv2rgb_pkg::FIELD_W-1:0] hue,
    input  wire logic [hsv2rgb_pkg::FIELD_W-1:0] saturation,
    input  wire logic [hsv2rgb_pkg::FIELD_W-1:0] brightness,
    output logic                                 rgb_valid,
    input  wire logic                            rgb_stall,
    output logic [hsv2rgb_pkg::FIELD_W-1:0]      red,
    output logic [hsv2rgb_pkg::FIELD_W-1:0]      green,
    output logic [hsv2rgb_pkg::FIELD_W-1:0]      blue
);

    logic [3:0] valid_reg;
    logic [3:0] valid_next;
    logic       advance;

    hsv2rgb_pkg::sect_t sect;
    hsv2rgb_pkg::term_t term;

    // Advance the whole pipe unless a finished result is held at the output
    assign advance   = !valid_reg[3] || !rgb_stall;
    assign hsv_stall = !advance;
    assign rgb_valid = valid_reg[3];

    // Shift valid bits along with the data
    assign valid_next = {valid_reg[2:0], hsv_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    hsv2rgb_sector u_sector (
        .clk        (clk),
        .advance    (advance),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .sect       (sect)
    );

    hsv2rgb_terms u_terms (
        .clk     (clk),
        .advance (advance),
        .sect    (sect),
        .term    (term)
    );

    hsv2rgb_route u_route (
        .clk     (clk),
        .advance (advance),
        .term    (term),
        .red     (red),
        .green   (green),
        .blue    (blue)
    );

endmodule

`default_nettype wire
